/* rtl/sem_pkg.sv */
`timescale 1ns / 1ps

package sem_pkg;

  localparam int PIX_W       = 8;
  localparam int NUM_CH      = 3;
  localparam int RGB_W       = PIX_W * NUM_CH;
  localparam int G_W         = 11;  // gradient range -1020..1020
  localparam int SUM_W       = 21;  // gx^2 + gy^2 <= 2080800
  localparam int FW_REG_W    = 12;
  localparam int FH_REG_W    = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } sem_cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } sem_kind_e;

  // Neighbourhood validity and end-of-frame mark for one result request
  typedef struct packed {
    logic top_ok;
    logic bottom_ok;
    logic left_ok;
    logic right_ok;
    logic frame_end;
  } sem_req_flags_t;

endpackage

/* rtl/sem_queue.sv */
`timescale 1ns / 1ps

module sem_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);
  import sem_pkg::*;

  logic [DW-1:0]     store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    do_push = push_i & ~full_o;
    do_pop  = pop_i & valid_o;
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d   = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/sem_front.sv */
`timescale 1ns / 1ps

module sem_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int RING_D     = 4112
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [sem_pkg::PIX_W-1:0]           red_in_i,
  input  logic [sem_pkg::PIX_W-1:0]           green_in_i,
  input  logic [sem_pkg::PIX_W-1:0]           blue_in_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output logic [$clog2(RING_D)-1:0]           push_base_o,
  output sem_pkg::sem_req_flags_t             push_flags_o,
  output logic                                we_o,
  output logic [$clog2(RING_D)-1:0]           waddr_o,
  output logic [sem_pkg::RGB_W-1:0]           wdata_o,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      width_o
);
  import sem_pkg::*;

  localparam int SLOT_W = $clog2(RING_D);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PEND_W = $clog2(MAX_WIDTH + 4);
  localparam int CMP_W  = ((POS_W > PEND_W) ? POS_W : PEND_W) + 1;
  localparam int W_RST  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int H_RST  = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [WD_W-1:0]   w_q, w_d;
  logic [HT_W-1:0]   h_q, h_d;
  logic [COL_W-1:0]  in_col_q, in_col_n, out_col_q, out_col_n;
  logic [ROW_W-1:0]  in_row_q, in_row_n, out_row_q, out_row_n;
  logic [POS_W-1:0]  in_pos_q, in_pos_n, out_pos_q, out_pos_n;
  logic [PEND_W-1:0] pend_q, pend_n, pend_d;
  logic [SLOT_W-1:0] wslot_q, wslot_n;
  logic [POS_W:0]    lead;
  logic [SLOT_W:0]   wslot_x, pend_x;
  logic [31:0]       cfg_w, cfg_h;
  logic              is_pix, fire, due;
  logic              in_last_col, in_last_row, out_bot_ok, out_right_ok;

  assign in_ready_o = ~q_full_i;
  assign width_o    = w_q;
  assign we_o       = fire & is_pix;
  assign waddr_o    = wslot_q;
  assign wdata_o    = {red_in_i, green_in_i, blue_in_i};
  assign push_o     = fire & due;

  // Register values are clamped on the way in: zero acts as one, above max as max
  always_comb begin
    cfg_w = 32'(cfg_data_i[FW_REG_W-1:0]);
    cfg_h = 32'(cfg_data_i[FH_REG_W-1:0]);
    if (cfg_w == 32'd0) cfg_w = 32'd1;
    else if (cfg_w > 32'(MAX_WIDTH)) cfg_w = 32'(MAX_WIDTH);
    if (cfg_h == 32'd0) cfg_h = 32'd1;
    else if (cfg_h > 32'(MAX_HEIGHT)) cfg_h = 32'(MAX_HEIGHT);
    w_d = w_q;
    h_d = h_q;
    unique case (cfg_index_i)
      CFG_FRAME_WIDTH:  w_d = WD_W'(cfg_w);
      CFG_FRAME_HEIGHT: h_d = HT_W'(cfg_h);
    endcase
  end

  always_comb begin
    is_pix = (kind_i == KIND_PIXEL);
    fire   = in_valid_i & in_ready_o;

    in_last_col = (WD_W'(in_col_q) + WD_W'(1)) == w_q;
    in_last_row = (HT_W'(in_row_q) + HT_W'(1)) == h_q;
    in_col_n = in_col_q;
    in_row_n = in_row_q;
    in_pos_n = in_pos_q;
    if (is_pix) begin
      if (in_last_col) begin
        in_col_n = '0;
        if (in_last_row) begin
          in_row_n = '0;
          in_pos_n = '0;
        end else begin
          in_row_n = in_row_q + 1'b1;
          in_pos_n = in_pos_q + 1'b1;
        end
      end else begin
        in_col_n = in_col_q + 1'b1;
        in_pos_n = in_pos_q + 1'b1;
      end
    end
    pend_n = pend_q + PEND_W'(is_pix);

    // Oldest waiting pixel is due once its bottom-right in-frame neighbour is in,
    // or at once if it belongs to an earlier frame
    out_bot_ok   = (HT_W'(out_row_q) + HT_W'(1)) < h_q;
    out_right_ok = (WD_W'(out_col_q) + WD_W'(1)) < w_q;
    lead = (POS_W+1)'(out_pos_q) + (out_bot_ok ? (POS_W+1)'(w_q) : '0)
         + (POS_W+1)'(out_right_ok);
    due = (pend_n != '0) &&
          ((CMP_W'(pend_n) > CMP_W'(in_pos_n)) || (lead < (POS_W+1)'(in_pos_n)));

    wslot_n = wslot_q;
    if (is_pix) begin
      wslot_n = (wslot_q == SLOT_W'(RING_D - 1)) ? '0 : wslot_q + 1'b1;
    end
    wslot_x = (SLOT_W+1)'(wslot_n);
    pend_x  = (SLOT_W+1)'(pend_n);
    if (wslot_x >= pend_x) push_base_o = SLOT_W'(wslot_x - pend_x);
    else push_base_o = SLOT_W'(wslot_x + (SLOT_W+1)'(RING_D) - pend_x);

    push_flags_o.top_ok    = (out_row_q != '0);
    push_flags_o.bottom_ok = out_bot_ok;
    push_flags_o.left_ok   = (out_col_q != '0);
    push_flags_o.right_ok  = out_right_ok;
    push_flags_o.frame_end = ~out_bot_ok & ~out_right_ok;

    out_col_n = out_col_q;
    out_row_n = out_row_q;
    out_pos_n = out_pos_q;
    pend_d    = pend_n;
    if (due) begin
      pend_d = pend_n - 1'b1;
      if (!out_right_ok) begin
        out_col_n = '0;
        if (!out_bot_ok) begin
          out_row_n = '0;
          out_pos_n = '0;
        end else begin
          out_row_n = out_row_q + 1'b1;
          out_pos_n = out_pos_q + 1'b1;
        end
      end else begin
        out_col_n = out_col_q + 1'b1;
        out_pos_n = out_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WD_W'(W_RST);
      h_q       <= HT_W'(H_RST);
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_pos_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_pos_q <= '0;
      pend_q    <= '0;
      wslot_q   <= '0;
    end else if (cfg_valid_i) begin
      // a register write restarts the stream
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_pos_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_pos_q <= '0;
      pend_q    <= '0;
      wslot_q   <= '0;
    end else if (fire) begin
      in_col_q  <= in_col_n;
      in_row_q  <= in_row_n;
      in_pos_q  <= in_pos_n;
      out_col_q <= out_col_n;
      out_row_q <= out_row_n;
      out_pos_q <= out_pos_n;
      pend_q    <= pend_d;
      wslot_q   <= wslot_n;
    end
  end

endmodule

/* rtl/sem_back.sv */
`timescale 1ns / 1ps

module sem_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int RING_D    = 4112
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [$clog2(RING_D)-1:0]      waddr_i,
  input  logic [sem_pkg::RGB_W-1:0]      wdata_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width_i,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [$clog2(RING_D)-1:0]      req_base_i,
  input  sem_pkg::sem_req_flags_t        req_flags_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]      edge_red_o,
  output logic [sem_pkg::PIX_W-1:0]      edge_green_o,
  output logic [sem_pkg::PIX_W-1:0]      edge_blue_o,
  output logic                           frame_end_o
);
  import sem_pkg::*;

  localparam int SLOT_W = $clog2(RING_D);
  localparam logic [1:0] STEP_LEFT  = 2'd0;
  localparam logic [1:0] STEP_MID   = 2'd1;
  localparam logic [1:0] STEP_RIGHT = 2'd2;
  localparam logic [1:0] STEP_LAST  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_OUT
  } state_e;

  // Three copies of the pixel ring, one per window row, written alike
  logic [RGB_W-1:0] mem_up [RING_D];
  logic [RGB_W-1:0] mem_mid [RING_D];
  logic [RGB_W-1:0] mem_dn [RING_D];

  state_e             state_q;
  logic [1:0]         step_q, rd_col_q;
  logic               rd_vld_q;
  logic [2:0]         bit_q;
  logic [SLOT_W-1:0]  base_up_q, base_mid_q, base_dn_q;
  logic [SLOT_W-1:0]  addr_up, addr_mid, addr_dn, up_calc, dn_calc;
  logic [SLOT_W:0]    base_x, w_x, dn_sum;
  logic [RGB_W-1:0]   rd_up_q, rd_mid_q, rd_dn_q;
  sem_req_flags_t     flags_q;
  logic               col_ok, up_ok, mid_ok, dn_ok;

  logic signed [G_W-1:0]     gx_q [NUM_CH];
  logic signed [G_W-1:0]     gy_q [NUM_CH];
  logic signed [G_W-1:0]     gx_acc [NUM_CH];
  logic signed [G_W-1:0]     gy_acc [NUM_CH];
  logic signed [G_W-1:0]     cs_s [NUM_CH];
  logic signed [G_W-1:0]     diff [NUM_CH];
  logic [PIX_W-1:0]          pa [NUM_CH];
  logic [PIX_W-1:0]          pb [NUM_CH];
  logic [PIX_W-1:0]          pc [NUM_CH];
  logic [PIX_W+1:0]          colsum [NUM_CH];
  logic signed [2*G_W-1:0]   gx2 [NUM_CH];
  logic signed [2*G_W-1:0]   gy2 [NUM_CH];
  logic [SUM_W-1:0]          sq_calc [NUM_CH];
  logic [SUM_W-1:0]          sq_q [NUM_CH];
  logic [PIX_W-1:0]          root_q [NUM_CH];
  logic [PIX_W-1:0]          cand [NUM_CH];
  logic [2*PIX_W-1:0]        prod [NUM_CH];
  logic [NUM_CH-1:0]         take;

  logic                      out_valid_q;
  logic [PIX_W-1:0]          edge_r_q, edge_g_q, edge_b_q;
  logic                      frame_end_q;

  function automatic logic [SLOT_W-1:0] col_addr(input logic [SLOT_W-1:0] b,
                                                  input logic [1:0] s);
    logic [SLOT_W-1:0] a;
    a = b;
    if (s == STEP_LEFT) begin
      a = (b == '0) ? SLOT_W'(RING_D - 1) : b - 1'b1;
    end else if (s == STEP_RIGHT) begin
      a = (b == SLOT_W'(RING_D - 1)) ? '0 : b + 1'b1;
    end
    return a;
  endfunction

  assign req_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign edge_red_o   = edge_r_q;
  assign edge_green_o = edge_g_q;
  assign edge_blue_o  = edge_b_q;
  assign frame_end_o  = frame_end_q;

  // Row bases one line up and down around the requested slot
  always_comb begin
    base_x = (SLOT_W+1)'(req_base_i);
    w_x    = (SLOT_W+1)'(width_i);
    if (base_x >= w_x) up_calc = SLOT_W'(base_x - w_x);
    else up_calc = SLOT_W'(base_x + (SLOT_W+1)'(RING_D) - w_x);
    dn_sum = base_x + w_x;
    if (dn_sum >= (SLOT_W+1)'(RING_D)) dn_calc = SLOT_W'(dn_sum - (SLOT_W+1)'(RING_D));
    else dn_calc = SLOT_W'(dn_sum);

    addr_up  = col_addr(base_up_q, step_q);
    addr_mid = col_addr(base_mid_q, step_q);
    addr_dn  = col_addr(base_dn_q, step_q);
  end

  always_comb begin
    col_ok = 1'b1;
    if (rd_col_q == STEP_LEFT) col_ok = flags_q.left_ok;
    else if (rd_col_q == STEP_RIGHT) col_ok = flags_q.right_ok;
    up_ok  = col_ok & flags_q.top_ok;
    mid_ok = col_ok;
    dn_ok  = col_ok & flags_q.bottom_ok;

    for (int ch = 0; ch < NUM_CH; ch++) begin
      pa[ch] = up_ok  ? rd_up_q[PIX_W*(NUM_CH-1-ch) +: PIX_W]  : '0;
      pb[ch] = mid_ok ? rd_mid_q[PIX_W*(NUM_CH-1-ch) +: PIX_W] : '0;
      pc[ch] = dn_ok  ? rd_dn_q[PIX_W*(NUM_CH-1-ch) +: PIX_W]  : '0;
      colsum[ch] = (PIX_W+2)'(pa[ch]) + (PIX_W+2)'({pb[ch], 1'b0}) + (PIX_W+2)'(pc[ch]);
      cs_s[ch]   = $signed(G_W'(colsum[ch]));
      diff[ch]   = $signed(G_W'(pc[ch])) - $signed(G_W'(pa[ch]));
      gx_acc[ch] = gx_q[ch];
      gy_acc[ch] = gy_q[ch];
      case (rd_col_q)
        STEP_LEFT: begin
          gx_acc[ch] = gx_q[ch] - cs_s[ch];
          gy_acc[ch] = gy_q[ch] + diff[ch];
        end
        STEP_MID: begin
          gy_acc[ch] = gy_q[ch] + (diff[ch] <<< 1);
        end
        STEP_RIGHT: begin
          gx_acc[ch] = gx_q[ch] + cs_s[ch];
          gy_acc[ch] = gy_q[ch] + diff[ch];
        end
        default: begin
          gx_acc[ch] = gx_q[ch];
          gy_acc[ch] = gy_q[ch];
        end
      endcase

      gx2[ch]     = gx_q[ch] * gx_q[ch];
      gy2[ch]     = gy_q[ch] * gy_q[ch];
      sq_calc[ch] = SUM_W'($unsigned(gx2[ch])) + SUM_W'($unsigned(gy2[ch]));

      // bitwise search for the largest r with r*(r-1) < s
      cand[ch]  = root_q[ch] | (PIX_W'(1) << bit_q);
      prod[ch]  = (2*PIX_W)'(cand[ch]) * (2*PIX_W)'(cand[ch] - 1'b1);
      take[ch]  = SUM_W'(prod[ch]) < sq_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_up[waddr_i]  <= wdata_i;
      mem_mid[waddr_i] <= wdata_i;
      mem_dn[waddr_i]  <= wdata_i;
    end
    rd_up_q  <= mem_up[addr_up];
    rd_mid_q <= mem_mid[addr_mid];
    rd_dn_q  <= mem_dn[addr_dn];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_LEFT;
      rd_col_q    <= STEP_LEFT;
      rd_vld_q    <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_READ) && (step_q != STEP_LAST);
      rd_col_q <= step_q;
      if (rd_vld_q) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          gx_q[ch] <= gx_acc[ch];
          gy_q[ch] <= gy_acc[ch];
        end
      end
      // ST_OUT reloads the output itself whenever the request leaves
      if (out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            base_mid_q <= req_base_i;
            base_up_q  <= up_calc;
            base_dn_q  <= dn_calc;
            flags_q    <= req_flags_i;
            step_q     <= STEP_LEFT;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              gx_q[ch] <= '0;
              gy_q[ch] <= '0;
            end
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_LAST) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            sq_q[ch]   <= sq_calc[ch];
            root_q[ch] <= '0;
          end
          bit_q   <= 3'(PIX_W - 1);
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            if (take[ch]) root_q[ch] <= cand[ch];
          end
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            edge_r_q    <= root_q[0];
            edge_g_q    <= root_q[1];
            edge_b_q    <= root_q[2];
            frame_end_q <= flags_q.frame_end;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/sobel_edge_magnitude_rgb_unit.sv */
`timescale 1ns / 1ps

// Sobel 3x3 edge magnitude on an RGB raster stream with zero padding at the
// frame border. Each channel gives min(255, round(sqrt(Gx^2 + Gy^2))). The
// input side takes one request per cycle while its four-entry request queue
// has room; a pixel's result is released once its in-frame neighbours one
// row and one column further on have arrived (at most w+1 pixels of lag),
// and flush requests drain the tail of a frame. The result engine works on
// one request at a time: it dequeues, reads the three window columns from
// the three copies of the pixel ring, squares and adds, runs the bitwise
// root search and hands over to the output register. The pixel ring holds
// 2*MAX_WIDTH+16 entries in each copy and needs no clearing after reset.
// Writing frame_width or frame_height restarts the stream and drops results
// not yet queued.
module sobel_edge_magnitude_rgb_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [sem_pkg::PIX_W-1:0]      red_in_i,
  input  logic [sem_pkg::PIX_W-1:0]      green_in_i,
  input  logic [sem_pkg::PIX_W-1:0]      blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]      edge_red_o,
  output logic [sem_pkg::PIX_W-1:0]      edge_green_o,
  output logic [sem_pkg::PIX_W-1:0]      edge_blue_o,
  output logic                           frame_end_o
);
  import sem_pkg::*;

  localparam int RING_D = 2 * MAX_WIDTH + 16;
  localparam int SLOT_W = $clog2(RING_D);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int FLG_W  = $bits(sem_req_flags_t);
  localparam int REQ_W  = SLOT_W + FLG_W;

  logic                q_full, push, we, q_valid, q_pop;
  logic [SLOT_W-1:0]   push_base, waddr;
  sem_req_flags_t      push_flags, head_flags;
  logic [RGB_W-1:0]    wdata;
  logic [WD_W-1:0]     width;
  logic [REQ_W-1:0]    head;

  assign cfg_ready_o = 1'b1;
  assign head_flags  = sem_req_flags_t'(head[FLG_W-1:0]);

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RING_D     (RING_D)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_base_o  (push_base),
    .push_flags_o (push_flags),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .width_o      (width)
  );

  sem_queue #(
    .DW (REQ_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_base, push_flags}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head)
  );

  sem_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .RING_D    (RING_D)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (we),
    .waddr_i      (waddr),
    .wdata_i      (wdata),
    .width_i      (width),
    .req_valid_i  (q_valid),
    .req_ready_o  (q_pop),
    .req_base_i   (head[REQ_W-1:FLG_W]),
    .req_flags_i  (head_flags),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .edge_red_o   (edge_red_o),
    .edge_green_o (edge_green_o),
    .edge_blue_o  (edge_blue_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
